[rtl/core/rwlf_pkg.sv]
// ----------------------------------------------------------------------------
// rwlf_pkg: shared types and constants of the reader/writer lock queue
// Action and outcome codes, queue sizing and the controller interface.
// ----------------------------------------------------------------------------
package rwlf_pkg;

  // queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_BITS     = 8;

  // read hold counter and reader run limits
  localparam int HOLD_BITS = 16;
  localparam logic [HOLD_BITS-1:0] READ_MAX = {HOLD_BITS{1'b1}};
  localparam int MAX_RUN  = 16;
  localparam int RUN_BITS = $clog2(MAX_RUN + 1);

  localparam int ACT_BITS = 3;
  localparam int OUT_BITS = 3;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_TRY_READ     = 3'd0,
    ACT_LOCK_READ    = 3'd1,
    ACT_UNLOCK_READ  = 3'd2,
    ACT_TRY_WRITE    = 3'd3,
    ACT_LOCK_WRITE   = 3'd4,
    ACT_UNLOCK_WRITE = 3'd5
  } action_t;

  typedef enum logic [OUT_BITS-1:0] {
    OUT_GRANTED        = 3'd0,
    OUT_QUEUED         = 3'd1,
    OUT_REFUSED        = 3'd2,
    OUT_GRANTED_WAITER = 3'd3,
    OUT_RELEASED       = 3'd4,
    OUT_QUEUE_FULL     = 3'd5,
    OUT_MISUSE         = 3'd6
  } outcome_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted request
    logic exec;       // decide the request and update lock state
    logic step;       // emit pending waiter grant, continue reader run
    logic cfg_write;  // register write transfer
  } rwlf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic run_start;  // request opens a run of reader grants
    logic run_more;   // another waiting reader follows in the run
  } rwlf_sts_t;

endpackage

[rtl/core/reader_writer_lock_fifo.sv]
// A transferred request is captured, then decided in the execute state once
// the output register is free; the first grant of a reader run after a release
// passes through the pending stage first. Requests are taken one at a time, and
// a reader grant run holds the request until its last grant is loaded.
// The next request is accepted only after its last result is in the output register.
// Reset: synchronous, active low; lock counts and queue pointers clear at once.
// ----------------------------------------------------------------------------
// reader_writer_lock_fifo: fair single-writer, multi-reader lock arbiter
// Grants read and write holds, queues blocking requests in a circular FIFO
// and grants waiters in order as the lock is released.
// ----------------------------------------------------------------------------
module reader_writer_lock_fifo
  import rwlf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACT_BITS-1:0]  in_action,
  input  logic [ID_BITS-1:0]   in_requester,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_BITS-1:0]  out_outcome,
  output logic [ID_BITS-1:0]   out_grantee,
  output logic                 out_grantee_writes,
  output logic [HOLD_BITS-1:0] out_readers_holding,
  output logic                 out_writer_holding,
  output logic [CNT_BITS-1:0]  out_waiting,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CNT_BITS-1:0]  cfg_queue_slots
);

  rwlf_cmd_t cmd;
  rwlf_sts_t sts;

  // request sequencer
  rwlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // lock state, waiter ring and result register
  rwlf_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_action           (in_action),
    .in_requester        (in_requester),
    .cfg_queue_slots     (cfg_queue_slots),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_outcome         (out_outcome),
    .out_grantee         (out_grantee),
    .out_grantee_writes  (out_grantee_writes),
    .out_readers_holding (out_readers_holding),
    .out_writer_holding  (out_writer_holding),
    .out_waiting         (out_waiting),
    .out_last            (out_last)
  );

endmodule

[rtl/core/rwlf_ctrl.sv]
// ----------------------------------------------------------------------------
// rwlf_ctrl: request sequencer of the reader/writer lock queue
// Accepts one request at a time, runs its decision step and steps through
// reader grant runs one result per cycle while the output register is free.
// ----------------------------------------------------------------------------
module rwlf_ctrl
  import rwlf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  rwlf_sts_t sts,
  output rwlf_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_GRANT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cfg_ready     = 1'b0;
    cmd.capture   = 1'b0;
    cmd.exec      = 1'b0;
    cmd.step      = 1'b0;
    cmd.cfg_write = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cfg_ready     = 1'b1;
        cmd.cfg_write = cfg_valid;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = sts.run_start ? S_GRANT : S_IDLE;
        end
      end
      S_GRANT: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          if (!sts.run_more) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/rwlf_dpath.sv]
// ----------------------------------------------------------------------------
// rwlf_dpath: lock state, waiter ring and result register
// Holds read/write lock counts, the circular queue of waiters, the pending
// reader grant of a run and the registered result channel.
// ----------------------------------------------------------------------------
module rwlf_dpath
  import rwlf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  rwlf_cmd_t            cmd,
  output rwlf_sts_t            sts,
  input  logic [ACT_BITS-1:0]  in_action,
  input  logic [ID_BITS-1:0]   in_requester,
  input  logic [CNT_BITS-1:0]  cfg_queue_slots,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_BITS-1:0]  out_outcome,
  output logic [ID_BITS-1:0]   out_grantee,
  output logic                 out_grantee_writes,
  output logic [HOLD_BITS-1:0] out_readers_holding,
  output logic                 out_writer_holding,
  output logic [CNT_BITS-1:0]  out_waiting,
  output logic                 out_last
);

  // captured request
  action_t              act_r;
  logic [ID_BITS-1:0]   who_r;

  // lock state
  logic [CNT_BITS-1:0]  slots_r, slots_nxt;
  logic [SLOT_BITS-1:0] head_r, head_nxt;
  logic [SLOT_BITS-1:0] tail_r, tail_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [HOLD_BITS-1:0] holds_r, holds_nxt;
  logic                 wh_r, wh_nxt;
  logic [RUN_BITS-1:0]  run_r, run_nxt;

  // pending reader grant of a run
  logic [ID_BITS-1:0]   pend_who_r;
  logic [HOLD_BITS-1:0] pend_holds_r;
  logic [CNT_BITS-1:0]  pend_cnt_r;
  logic                 pend_load;

  // waiter ring, entries undefined until written
  logic                 slot_wr_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   slot_id_mem [QUEUE_DEPTH];
  logic                 enq;
  logic                 enq_wr;

  // registered head entry of the ring
  logic                 head_wr_r;
  logic [ID_BITS-1:0]   head_id_r;

  // result register
  logic                 out_valid_r;
  logic [OUT_BITS-1:0]  out_outcome_r;
  logic [ID_BITS-1:0]   out_grantee_r;
  logic                 out_grantee_writes_r;
  logic [HOLD_BITS-1:0] out_readers_holding_r;
  logic                 out_writer_holding_r;
  logic [CNT_BITS-1:0]  out_waiting_r;
  logic                 out_last_r;

  // result being loaded
  logic                 o_load;
  outcome_t             o_outcome;
  logic [ID_BITS-1:0]   o_who;
  logic                 o_wr;
  logic                 o_last;
  logic                 o_from_pend;

  // helpers
  logic                 head_wr;
  logic [ID_BITS-1:0]   head_id;
  logic [SLOT_BITS-1:0] head_next_slot;
  logic [SLOT_BITS-1:0] tail_next_slot;
  logic [CNT_BITS-1:0]  head_inc;
  logic [CNT_BITS-1:0]  tail_inc;
  logic                 full;
  logic                 out_free;
  logic                 run_more;
  logic                 run_start;
  logic                 act_write;
  logic [HOLD_BITS-1:0] rel_holds;
  logic                 rel_wh;
  logic [CNT_BITS-1:0]  cfg_clamped;

  // head entry and ring wrap
  assign head_wr        = head_wr_r;
  assign head_id        = head_id_r;
  assign head_inc       = CNT_BITS'(head_r) + CNT_BITS'(1);
  assign tail_inc       = CNT_BITS'(tail_r) + CNT_BITS'(1);
  assign head_next_slot = (head_inc >= slots_r) ? '0 : head_inc[SLOT_BITS-1:0];
  assign tail_next_slot = (tail_inc >= slots_r) ? '0 : tail_inc[SLOT_BITS-1:0];
  assign full           = (cnt_r >= slots_r);
  assign out_free       = !out_valid_r || out_ready;
  assign act_write      = (act_r == ACT_TRY_WRITE) || (act_r == ACT_LOCK_WRITE) ||
                          (act_r == ACT_UNLOCK_WRITE);
  assign run_more       = (cnt_r != '0) && (run_r < RUN_BITS'(MAX_RUN)) &&
                          (holds_r != READ_MAX) && !head_wr;

  // register value clamped to the ring size
  assign cfg_clamped = (cfg_queue_slots == '0) ? CNT_BITS'(1) :
                       (cfg_queue_slots > CNT_BITS'(QUEUE_DEPTH)) ?
                       CNT_BITS'(QUEUE_DEPTH) : cfg_queue_slots;

  assign sts = '{out_free: out_free, run_start: run_start, run_more: run_more};

  // request decision, queue moves and lock count updates
  always_comb begin
    slots_nxt   = slots_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    holds_nxt   = holds_r;
    wh_nxt      = wh_r;
    run_nxt     = run_r;
    enq         = 1'b0;
    enq_wr      = act_write;
    pend_load   = 1'b0;
    o_load      = 1'b0;
    o_outcome   = OUT_MISUSE;
    o_who       = who_r;
    o_wr        = act_write;
    o_last      = 1'b1;
    o_from_pend = 1'b0;
    run_start   = 1'b0;
    rel_holds   = holds_r;
    rel_wh      = wh_r;

    if (cmd.exec) begin
      o_load = 1'b1;
      unique case (act_r) inside
        ACT_TRY_READ, ACT_LOCK_READ, ACT_TRY_WRITE, ACT_LOCK_WRITE: begin
          if (!wh_r && cnt_r == '0 && (!act_write || holds_r == '0)) begin
            if (!act_write && holds_r == READ_MAX) begin
              o_outcome = OUT_REFUSED;
            end else begin
              o_outcome = OUT_GRANTED;
              if (act_write) begin
                wh_nxt = 1'b1;
              end else begin
                holds_nxt = holds_r + HOLD_BITS'(1);
              end
            end
          end else if (act_r == ACT_TRY_READ || act_r == ACT_TRY_WRITE) begin
            o_outcome = OUT_REFUSED;
          end else if (full) begin
            o_outcome = OUT_QUEUE_FULL;
          end else begin
            o_outcome = OUT_QUEUED;
            enq       = 1'b1;
            tail_nxt  = tail_next_slot;
            cnt_nxt   = cnt_r + CNT_BITS'(1);
          end
        end
        ACT_UNLOCK_READ, ACT_UNLOCK_WRITE: begin
          if (act_write ? !wh_r : (holds_r == '0 || wh_r)) begin
            o_outcome = OUT_MISUSE;
          end else begin
            if (act_write) begin
              rel_wh = 1'b0;
            end else begin
              rel_holds = holds_r - HOLD_BITS'(1);
            end
            holds_nxt = rel_holds;
            wh_nxt    = rel_wh;
            if (rel_holds == '0 && !rel_wh && cnt_r != '0) begin
              // lock just freed with waiters: grant the head
              head_nxt = head_next_slot;
              cnt_nxt  = cnt_r - CNT_BITS'(1);
              if (head_wr) begin
                o_outcome = OUT_GRANTED_WAITER;
                o_who     = head_id;
                o_wr      = 1'b1;
                wh_nxt    = 1'b1;
              end else begin
                // first reader of a run goes to the pending stage
                o_load    = 1'b0;
                run_start = 1'b1;
                holds_nxt = HOLD_BITS'(1);
                pend_load = 1'b1;
                run_nxt   = RUN_BITS'(1);
              end
            end else begin
              o_outcome = OUT_RELEASED;
            end
          end
        end
        default: o_outcome = OUT_MISUSE;
      endcase
    end

    // reader run: emit pending grant, pop the next reader if any
    if (cmd.step) begin
      o_load      = 1'b1;
      o_from_pend = 1'b1;
      o_outcome   = OUT_GRANTED_WAITER;
      o_who       = pend_who_r;
      o_wr        = 1'b0;
      o_last      = !run_more;
      if (run_more) begin
        head_nxt  = head_next_slot;
        cnt_nxt   = cnt_r - CNT_BITS'(1);
        holds_nxt = holds_r + HOLD_BITS'(1);
        pend_load = 1'b1;
        run_nxt   = run_r + RUN_BITS'(1);
      end
    end

    // register write, taken only with an empty queue
    if (cmd.cfg_write && cnt_r == '0) begin
      slots_nxt = cfg_clamped;
      head_nxt  = '0;
      tail_nxt  = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r     <= CNT_BITS'(QUEUE_DEPTH);
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      holds_r     <= '0;
      wh_r        <= 1'b0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slots_r     <= slots_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      holds_r     <= holds_nxt;
      wh_r        <= wh_nxt;
      run_r       <= run_nxt;
      out_valid_r <= o_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    end
  end

  // request capture, pending grant and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= action_t'(in_action);
      who_r <= in_requester;
    end
    if (pend_load) begin
      pend_who_r   <= head_id;
      pend_holds_r <= holds_nxt;
      pend_cnt_r   <= cnt_nxt;
    end
    if (o_load) begin
      out_outcome_r         <= o_outcome;
      out_grantee_r         <= o_who;
      out_grantee_writes_r  <= o_wr;
      out_readers_holding_r <= o_from_pend ? pend_holds_r : holds_nxt;
      out_writer_holding_r  <= o_from_pend ? 1'b0 : wh_nxt;
      out_waiting_r         <= o_from_pend ? pend_cnt_r : cnt_nxt;
      out_last_r            <= o_last;
    end
  end

  // waiter ring write at the tail, registered read of the next head
  always_ff @(posedge clk) begin
    if (enq) begin
      slot_wr_mem[tail_r] <= enq_wr;
      slot_id_mem[tail_r] <= who_r;
    end
    if (enq && tail_r == head_nxt) begin
      head_wr_r <= enq_wr;
      head_id_r <= who_r;
    end else begin
      head_wr_r <= slot_wr_mem[head_nxt];
      head_id_r <= slot_id_mem[head_nxt];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_outcome         = out_outcome_r;
  assign out_grantee         = out_grantee_r;
  assign out_grantee_writes  = out_grantee_writes_r;
  assign out_readers_holding = out_readers_holding_r;
  assign out_writer_holding  = out_writer_holding_r;
  assign out_waiting         = out_waiting_r;
  assign out_last            = out_last_r;

  // waiter count stays within the slots in use
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= slots_r)
    else $error("waiter count exceeds ring slots");

  // a writer and readers never hold together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(wh_r && holds_r != '0))
    else $error("writer and readers hold at once");

  // waiters only exist while the lock is held
  a_wait_held: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (wh_r || holds_r != '0))
    else $error("waiters queued on a free lock");

  // a step that continues the run pops one waiter
  a_run_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && run_more) |=> (cnt_r == $past(cnt_r) - CNT_BITS'(1)))
    else $error("reader run step did not pop the head");

endmodule

[tb/reader_writer_lock_fifo_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reader_writer_lock_fifo_tb: self-checking bench for the lock arbiter
// A driver and a monitor run around a cycle-free predictor of the lock and
// its waiter ring. Directed requests, a writer hand-off pass and random
// request streams run under several ring sizes while both sides stall.
// ----------------------------------------------------------------------------
module reader_writer_lock_fifo_tb;
  import rwlf_pkg::*;

  // action codes the block does not define
  localparam logic [ACT_BITS-1:0] ACT_RSVD_A = 3'd6;
  localparam logic [ACT_BITS-1:0] ACT_RSVD_B = 3'd7;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [ACT_BITS-1:0] act;
    logic [ID_BITS-1:0]  id;
  } lock_request_t;

  typedef struct packed {
    outcome_t             outcome;
    logic [ID_BITS-1:0]   grantee;
    logic                 writes;
    logic [HOLD_BITS-1:0] readers;
    logic                 writer;
    logic [CNT_BITS-1:0]  waiting;
    logic                 last;
  } lock_result_t;

  typedef lock_result_t [MAX_RUN-1:0] result_run_t;

  typedef struct packed {
    logic [QUEUE_DEPTH-1:0]              is_wr;
    logic [QUEUE_DEPTH-1:0][ID_BITS-1:0] req;
    logic [SLOT_BITS-1:0]                head;
    logic [SLOT_BITS-1:0]                tail;
    logic [CNT_BITS-1:0]                 waiters;
    logic [HOLD_BITS-1:0]                reads;
    logic                                writer;
    logic [CNT_BITS-1:0]                 slots;
  } lock_state_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ACT_BITS-1:0]  in_action = '0;
  logic [ID_BITS-1:0]   in_requester = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_BITS-1:0]  out_outcome;
  logic [ID_BITS-1:0]   out_grantee;
  logic                 out_grantee_writes;
  logic [HOLD_BITS-1:0] out_readers_holding;
  logic                 out_writer_holding;
  logic [CNT_BITS-1:0]  out_waiting;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CNT_BITS-1:0]  cfg_queue_slots = '0;

  lock_state_t   lock_st;          // state as the block sees accepted requests
  lock_state_t   plan_st;          // state as seen while building stimulus
  lock_request_t requests_pending[$];
  lock_result_t  results_due[$];
  bit            in_taken = 1'b0;
  bit            bulk_mode = 1'b0;
  int            burst_left = 1;
  int            gap_left = 0;
  int            fail_count = 0;
  rx_mode_t      rx_mode = RX_STREAM;
  int            rx_left = 0;
  int            rx_phase = 0;

  reader_writer_lock_fifo u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_requester        (in_requester),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_outcome         (out_outcome),
    .out_grantee         (out_grantee),
    .out_grantee_writes  (out_grantee_writes),
    .out_readers_holding (out_readers_holding),
    .out_writer_holding  (out_writer_holding),
    .out_waiting         (out_waiting),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_queue_slots     (cfg_queue_slots)
  );

  // ring size in effect, clamped to the physical depth
  function automatic int slots_used(lock_state_t st);
    int s = st.slots;
    if (s < 1) s = 1;
    if (s > QUEUE_DEPTH) s = QUEUE_DEPTH;
    return s;
  endfunction

  function automatic logic [SLOT_BITS-1:0] next_slot(lock_state_t st,
                                                     logic [SLOT_BITS-1:0] i);
    int n = i + 1;
    if (n >= slots_used(st)) n = 0;
    return SLOT_BITS'(n);
  endfunction

  function automatic lock_result_t make_result(lock_state_t st, outcome_t oc,
                                               logic [ID_BITS-1:0] who, logic wr);
    lock_result_t r;
    r.outcome = oc;
    r.grantee = who;
    r.writes  = wr;
    r.readers = st.reads;
    r.writer  = st.writer;
    r.waiting = st.waiters;
    r.last    = 1'b0;
    return r;
  endfunction

  function automatic void enqueue_waiter(inout lock_state_t st, input logic wr,
                                         input logic [ID_BITS-1:0] who);
    st.is_wr[st.tail] = wr;
    st.req[st.tail]   = who;
    st.tail           = next_slot(st, st.tail);
    st.waiters        = st.waiters + 1'b1;
  endfunction

  function automatic logic [ID_BITS-1:0] pop_waiter(inout lock_state_t st);
    logic [ID_BITS-1:0] who;
    who        = st.req[st.head];
    st.head    = next_slot(st, st.head);
    st.waiters = st.waiters - 1'b1;
    return who;
  endfunction

  // lock just became free: head writer alone, or a run of head readers
  function automatic void grant_waiters(inout lock_state_t st, inout result_run_t res,
                                        inout int n);
    logic [ID_BITS-1:0] who;
    if (st.waiters == 0) return;
    if (st.is_wr[st.head]) begin
      who       = pop_waiter(st);
      st.writer = 1'b1;
      res[n]    = make_result(st, OUT_GRANTED_WAITER, who, 1'b1);
      n++;
      return;
    end
    while (st.waiters != 0 && n < MAX_RUN && st.reads < READ_MAX && !st.is_wr[st.head]) begin
      who      = pop_waiter(st);
      st.reads = st.reads + 1'b1;
      res[n]   = make_result(st, OUT_GRANTED_WAITER, who, 1'b0);
      n++;
    end
  endfunction

  // one request against the lock; returns the number of results
  function automatic int decide_request(inout lock_state_t st,
                                        input logic [ACT_BITS-1:0] act,
                                        input logic [ID_BITS-1:0] who,
                                        output result_run_t res);
    int   n;
    logic wr;
    n   = 0;
    res = '0;
    wr  = (act == ACT_TRY_WRITE || act == ACT_LOCK_WRITE || act == ACT_UNLOCK_WRITE);
    case (act)
      ACT_TRY_READ, ACT_LOCK_READ: begin
        if (!st.writer && st.waiters == 0) begin
          if (st.reads == READ_MAX) begin
            res[0] = make_result(st, OUT_REFUSED, who, 1'b0);
          end else begin
            st.reads = st.reads + 1'b1;
            res[0]   = make_result(st, OUT_GRANTED, who, 1'b0);
          end
        end else if (act == ACT_TRY_READ) begin
          res[0] = make_result(st, OUT_REFUSED, who, 1'b0);
        end else if (st.waiters >= slots_used(st)) begin
          res[0] = make_result(st, OUT_QUEUE_FULL, who, 1'b0);
        end else begin
          enqueue_waiter(st, 1'b0, who);
          res[0] = make_result(st, OUT_QUEUED, who, 1'b0);
        end
        n = 1;
      end
      ACT_TRY_WRITE, ACT_LOCK_WRITE: begin
        if (!st.writer && st.reads == 0 && st.waiters == 0) begin
          st.writer = 1'b1;
          res[0]    = make_result(st, OUT_GRANTED, who, 1'b1);
        end else if (act == ACT_TRY_WRITE) begin
          res[0] = make_result(st, OUT_REFUSED, who, 1'b1);
        end else if (st.waiters >= slots_used(st)) begin
          res[0] = make_result(st, OUT_QUEUE_FULL, who, 1'b1);
        end else begin
          enqueue_waiter(st, 1'b1, who);
          res[0] = make_result(st, OUT_QUEUED, who, 1'b1);
        end
        n = 1;
      end
      ACT_UNLOCK_READ: begin
        if (st.reads == 0 || st.writer) begin
          res[0] = make_result(st, OUT_MISUSE, who, 1'b0);
          n      = 1;
        end else begin
          st.reads = st.reads - 1'b1;
          if (st.reads == 0) grant_waiters(st, res, n);
          if (n == 0) begin
            res[0] = make_result(st, OUT_RELEASED, who, 1'b0);
            n      = 1;
          end
        end
      end
      ACT_UNLOCK_WRITE: begin
        if (!st.writer) begin
          res[0] = make_result(st, OUT_MISUSE, who, 1'b1);
          n      = 1;
        end else begin
          st.writer = 1'b0;
          if (st.reads == 0) grant_waiters(st, res, n);
          if (n == 0) begin
            res[0] = make_result(st, OUT_RELEASED, who, 1'b1);
            n      = 1;
          end
        end
      end
      default: begin
        res[0] = make_result(st, OUT_MISUSE, who, wr);
        n      = 1;
      end
    endcase
    res[n-1].last = 1'b1;
    return n;
  endfunction

  // ring size write, dropped while anyone waits
  function automatic void apply_slots(inout lock_state_t st, input logic [CNT_BITS-1:0] v);
    if (st.waiters != 0) return;
    st.slots = v;
    st.head  = '0;
    st.tail  = '0;
  endfunction

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #40ms;
    $display("** reader_writer_lock_fifo: FAILED **");
    $finish;
  end

  // request driver: bursts with random gaps
  always @(negedge clk) begin : drive_requests
    lock_request_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (requests_pending.size() != 0) begin
        item = requests_pending.pop_front();
        in_valid     <= 1'b1;
        in_action    <= item.act;
        in_requester <= item.id;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          if (bulk_mode || $urandom_range(0, 3) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // request transfer: predict its results
  always @(posedge clk) begin : accept_requests
    result_run_t run;
    int          count;
    if (rst_n && in_valid && in_ready) begin
      count = decide_request(lock_st, in_action, in_requester, run);
      for (int k = 0; k < count; k++) results_due.push_back(run[k]);
      in_taken = 1'b1;
    end
  end

  // result receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (bulk_mode && rx_mode == RX_SPARSE) rx_mode = RX_COIN;
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_STREAM: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= ((rx_phase % 8) < 5);
    endcase
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result transfer: compare with the oldest expected result
  always @(posedge clk) begin : check_results
    lock_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result, expected none, actual outcome %0d grantee %0d",
                 $time, out_outcome, out_grantee);
      end else begin
        want = results_due.pop_front();
        check_field("outcome", 16'(want.outcome), 16'(out_outcome));
        check_field("grantee", 16'(want.grantee), 16'(out_grantee));
        check_field("grantee_writes", 16'(want.writes), 16'(out_grantee_writes));
        check_field("readers_holding", want.readers, out_readers_holding);
        check_field("writer_holding", 16'(want.writer), 16'(out_writer_holding));
        check_field("waiting", 16'(want.waiting), 16'(out_waiting));
        check_field("last", 16'(want.last), 16'(out_last));
      end
    end
  end

  task automatic plan_item(input logic [ACT_BITS-1:0] act, input logic [ID_BITS-1:0] id);
    result_run_t   scratch;
    lock_request_t item;
    item.act = act;
    item.id  = id;
    void'(decide_request(plan_st, act, id, scratch));
    requests_pending.push_back(item);
  endtask

  // mostly matched lock/unlock traffic, some noise
  task automatic plan_random(input int count);
    logic [ACT_BITS-1:0] act;
    int                  r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 12) begin
        act = ACT_BITS'($urandom_range(0, 7));
      end else if (plan_st.writer) begin
        act = (r < 25) ? ACT_UNLOCK_WRITE : (r < 70) ? ACT_LOCK_READ :
              (r < 85) ? ACT_LOCK_WRITE : (r < 93) ? ACT_TRY_READ : ACT_TRY_WRITE;
      end else if (plan_st.reads != 0) begin
        act = (r < 40) ? ACT_UNLOCK_READ : (r < 70) ? ACT_LOCK_READ :
              (r < 85) ? ACT_LOCK_WRITE : (r < 93) ? ACT_TRY_READ : ACT_TRY_WRITE;
      end else begin
        act = (r < 40) ? ACT_LOCK_READ : (r < 70) ? ACT_LOCK_WRITE :
              (r < 85) ? ACT_TRY_READ : ACT_TRY_WRITE;
      end
      plan_item(act, ID_BITS'($urandom_range(0, 255)));
    end
  endtask

  // sender holds off until every expected result is in
  task automatic wait_idle();
    while (requests_pending.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slots(input logic [CNT_BITS-1:0] value);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_queue_slots <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_slots(lock_st, value);
    plan_st = lock_st;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : run_test
    logic [CNT_BITS-1:0] slot_settings [6];
    slot_settings = '{5'd2, 5'd0, 5'd16, 5'd1, 5'd17, 5'd9};
    lock_st       = '0;
    lock_st.slots = CNT_BITS'(QUEUE_DEPTH);
    plan_st       = lock_st;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: refusals, misuse, unknown actions, full ring, reader run
    plan_item(ACT_TRY_READ, 8'h00);
    plan_item(ACT_UNLOCK_WRITE, 8'hFF);
    plan_item(ACT_TRY_WRITE, 8'hAA);
    plan_item(ACT_RSVD_A, 8'h55);
    plan_item(ACT_RSVD_B, 8'h0F);
    plan_item(ACT_UNLOCK_READ, 8'hF0);
    plan_item(ACT_UNLOCK_READ, 8'h33);
    plan_item(ACT_LOCK_WRITE, 8'h01);
    plan_item(ACT_TRY_READ, 8'h02);
    plan_item(ACT_UNLOCK_READ, 8'hCC);
    for (int i = 0; i < QUEUE_DEPTH; i++) plan_item(ACT_LOCK_READ, ID_BITS'(8'h10 + i));
    plan_item(ACT_LOCK_WRITE, 8'h7E);
    plan_item(ACT_UNLOCK_WRITE, 8'h80);
    wait_idle();

    // readers hold, a writer waits with readers behind it, then hand-offs
    write_slots(5'd31);
    bulk_mode = 1'b1;
    plan_item(ACT_LOCK_READ, 8'h21);
    plan_item(ACT_LOCK_WRITE, 8'h23);
    plan_item(ACT_TRY_WRITE, 8'h24);
    plan_item(ACT_LOCK_READ, 8'h25);
    plan_item(ACT_TRY_READ, 8'h26);
    plan_item(ACT_LOCK_READ, 8'h27);
    while (plan_st.reads != 0)
      plan_item(ACT_UNLOCK_READ, ID_BITS'($urandom_range(0, 255)));
    plan_item(ACT_UNLOCK_WRITE, 8'h28);
    while (plan_st.reads != 0)
      plan_item(ACT_UNLOCK_READ, ID_BITS'($urandom_range(0, 255)));
    plan_item(ACT_UNLOCK_READ, 8'h29);
    wait_idle();
    bulk_mode = 1'b0;

    // random traffic under several ring sizes
    for (int c = 0; c < 6; c++) begin
      write_slots(slot_settings[c]);
      plan_random(50);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** reader_writer_lock_fifo: PASSED **");
    end else begin
      $display("** reader_writer_lock_fifo: FAILED **");
    end
    $finish;
  end

endmodule
